@@ sv/lurt_pkg.sv @@
// ============================================================================
// lurt_pkg
// Shared widths, default parameter values and the result record of the
// longest unique run tracker.
// ============================================================================
package lurt_pkg;

    // Widths of the port fields.
    localparam int SYMBOL_W = 8;
    localparam int START_W  = 12;
    localparam int LEN_W    = 13;

    // Default values of the top-level parameters.
    localparam int MAX_LEN_DEF     = 4096;
    localparam int SYMBOL_BITS_DEF = 8;

    // One result as it leaves the update stage.
    typedef struct packed {
        logic [START_W-1:0] best_start;
        logic [LEN_W-1:0]   best_length;
        logic [START_W-1:0] window_start;
        logic [LEN_W-1:0]   window_length;
        logic               overflow;
    } res_t;

endpackage

@@ sv/lurt_pos_ram.sv @@
// ============================================================================
// lurt_pos_ram
// Last-position table: one write port and one read port with a registered
// read. A read of the entry written at the same edge returns the old data.
// ============================================================================
module lurt_pos_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 12
) (
    input  logic              clk,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lurt_step.sv @@
// ============================================================================
// lurt_step
// Update stage: combines the last-position read with the per-symbol seen
// bits and the run registers, produces one result and, below the length
// limit, writes back table entry and run state when the transaction moves on.
// ============================================================================
module lurt_step #(
    parameter int MAX_LEN     = lurt_pkg::MAX_LEN_DEF,
    parameter int SYMBOL_BITS = lurt_pkg::SYMBOL_BITS_DEF,
    parameter int POS_W       = $clog2(MAX_LEN),
    parameter int CNT_W       = $clog2(MAX_LEN + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Item in the update stage and whether it moves on this cycle.
    input  logic                   go,
    input  logic [SYMBOL_BITS-1:0] s1_sym,
    input  logic                   s1_first,
    // Item being accepted into the stage at this edge.
    input  logic                   take,
    input  logic [SYMBOL_BITS-1:0] take_sym,
    // Table read data and write port.
    input  logic [POS_W-1:0]       ram_rdata,
    output logic                   wr_en,
    output logic [SYMBOL_BITS-1:0] wr_addr,
    output logic [POS_W-1:0]       wr_data,
    output lurt_pkg::res_t         res
);

    localparam int TABLE_SIZE = 1 << SYMBOL_BITS;
    localparam int START_W    = lurt_pkg::START_W;
    localparam int LEN_W      = lurt_pkg::LEN_W;

    logic [TABLE_SIZE-1:0] seen_reg, seen_next, seen_e, seen_set;
    logic [CNT_W-1:0]      cnt_reg, cnt_next, cnt_e, cnt_new;
    logic [POS_W-1:0]      run_reg, run_next, run_e, run_new;
    logic [POS_W-1:0]      best_start_reg, best_start_next, bs_e, bs_new;
    logic [CNT_W-1:0]      best_len_reg, best_len_next, bl_e, bl_new;
    logic                  fwd_hit_reg, fwd_hit_next;
    logic [POS_W-1:0]      fwd_pos_reg, fwd_pos_next;
    logic [POS_W-1:0]      last_pos;
    logic [CNT_W-1:0]      wlen;
    logic                  ovf, seen_hit, in_window, grow;

    // A new string starts from cleared history.
    always_comb
    begin
        seen_e = s1_first ? '0 : seen_reg;
        cnt_e  = s1_first ? '0 : cnt_reg;
        run_e  = s1_first ? '0 : run_reg;
        bs_e   = s1_first ? '0 : best_start_reg;
        bl_e   = s1_first ? '0 : best_len_reg;
    end

    // The entry written at the edge of the read comes from the bypass.
    assign last_pos = fwd_hit_reg ? fwd_pos_reg : ram_rdata;

    // Window move, new length and best-run update.
    always_comb
    begin
        ovf       = (cnt_e >= CNT_W'(MAX_LEN));
        seen_hit  = seen_e[s1_sym];
        in_window = seen_hit && (last_pos >= run_e);
        run_new   = in_window ? (last_pos + POS_W'(1)) : run_e;
        cnt_new   = cnt_e + CNT_W'(1);
        wlen      = cnt_new - CNT_W'(run_new);
        grow      = (wlen > bl_e);
        bl_new    = grow ? wlen : bl_e;
        bs_new    = grow ? run_new : bs_e;
        seen_set  = seen_e;
        seen_set[s1_sym] = 1'b1;
    end

    // Result fields, cut or extended to the port widths.
    always_comb
    begin
        if (ovf)
        begin
            res.best_start    = START_W'(bs_e);
            res.best_length   = LEN_W'(bl_e);
            res.window_start  = START_W'(run_e);
            res.window_length = LEN_W'(cnt_e - CNT_W'(run_e));
        end
        else
        begin
            res.best_start    = START_W'(bs_new);
            res.best_length   = LEN_W'(bl_new);
            res.window_start  = START_W'(run_new);
            res.window_length = LEN_W'(wlen);
        end
        res.overflow = ovf;
    end

    // Table write-back of the current position.
    assign wr_en   = go && !ovf;
    assign wr_addr = s1_sym;
    assign wr_data = cnt_e[POS_W-1:0];

    // Next state of the run registers.
    always_comb
    begin
        seen_next       = seen_reg;
        cnt_next        = cnt_reg;
        run_next        = run_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        if (go && !ovf)
        begin
            seen_next       = seen_set;
            cnt_next        = cnt_new;
            run_next        = run_new;
            best_start_next = bs_new;
            best_len_next   = bl_new;
        end
    end

    // Bypass for a read that meets the write of the same entry.
    always_comb
    begin
        fwd_hit_next = fwd_hit_reg;
        fwd_pos_next = fwd_pos_reg;
        if (take)
        begin
            fwd_hit_next = wr_en && (take_sym == s1_sym);
            fwd_pos_next = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            cnt_reg        <= '0;
            run_reg        <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            cnt_reg        <= cnt_next;
            run_reg        <= run_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            fwd_hit_reg    <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_pos_reg <= fwd_pos_next;
    end

    // The window never starts past the end of the string.
    assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(run_reg) <= cnt_reg)
        else $error("window start beyond symbol count");

    // The count never passes the string limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_LEN))
        else $error("symbol count beyond limit");

    // The best run is at least as long as the current window.
    assert property (@(posedge clk) disable iff (!rst_n)
        best_len_reg >= (cnt_reg - CNT_W'(run_reg)))
        else $error("best run shorter than current window");

endmodule

@@ sv/longest_unique_run_tracker.sv @@
// ============================================================================
// longest_unique_run_tracker
// Longest run of distinct symbols over a byte stream, using a last-position
// table in memory and a sliding window start.
// ============================================================================
//
//   Channel   Handshake              Payload
//   -------   --------------------   ---------------------------------------
//   input     sym_valid / sym_stall  symbol, first
//   result    res_valid / res_stall  best_start, best_length, window_start,
//                                    window_length, overflow
//
// One transaction per cycle is sustained while res_stall allows; a result is
// registered after the update stage, which reads the last-position table.
// Reset clears the run registers and the per-symbol seen bits; the table
// itself is not cleared and needs no clearing pass.
// A stalled result holds the output register; one more input transaction is
// taken into the update stage, after which sym_stall follows res_stall.
// ============================================================================
module longest_unique_run_tracker #(
    parameter int MAX_LEN     = lurt_pkg::MAX_LEN_DEF,
    parameter int SYMBOL_BITS = lurt_pkg::SYMBOL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sym_valid,
    output logic                          sym_stall,
    input  logic [lurt_pkg::SYMBOL_W-1:0] symbol,
    input  logic                          first,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [lurt_pkg::START_W-1:0]  best_start,
    output logic [lurt_pkg::LEN_W-1:0]    best_length,
    output logic [lurt_pkg::START_W-1:0]  window_start,
    output logic [lurt_pkg::LEN_W-1:0]    window_length,
    output logic                          overflow
);

    localparam int POS_W    = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int SYM_IN_W = lurt_pkg::SYMBOL_W;

    logic [SYMBOL_BITS-1:0] sym_addr;
    logic                   s1_valid_reg, s1_valid_next;
    logic [SYMBOL_BITS-1:0] s1_sym_reg;
    logic                   s1_first_reg;
    logic                   res_valid_reg, res_valid_next;
    lurt_pkg::res_t         res_reg, step_res;
    logic                   out_free, advance, take;
    logic [POS_W-1:0]       ram_rdata, wr_data;
    logic [SYMBOL_BITS-1:0] wr_addr;
    logic                   wr_en;

    // Table index from the low symbol bits, zero-extended if the table is wider.
    generate
        if (SYMBOL_BITS <= SYM_IN_W)
        begin : g_sym_cut
            assign sym_addr = symbol[SYMBOL_BITS-1:0];
        end
        else
        begin : g_sym_ext
            assign sym_addr = {{(SYMBOL_BITS - SYM_IN_W){1'b0}}, symbol};
        end
    endgenerate

    // Handshake: the update stage moves when the output register is free.
    assign out_free  = !res_valid_reg || !res_stall;
    assign advance   = s1_valid_reg && out_free;
    assign sym_stall = s1_valid_reg && !out_free;
    assign take      = sym_valid && !sym_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg && res_stall;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload of the update stage and of the output register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_sym_reg   <= sym_addr;
            s1_first_reg <= first;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    lurt_pos_ram #(
        .ADDR_W (SYMBOL_BITS),
        .DATA_W (POS_W)
    ) u_pos_ram (
        .clk   (clk),
        .re    (take),
        .raddr (sym_addr),
        .rdata (ram_rdata),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data)
    );

    lurt_step #(
        .MAX_LEN     (MAX_LEN),
        .SYMBOL_BITS (SYMBOL_BITS),
        .POS_W       (POS_W),
        .CNT_W       (CNT_W)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (advance),
        .s1_sym    (s1_sym_reg),
        .s1_first  (s1_first_reg),
        .take      (take),
        .take_sym  (sym_addr),
        .ram_rdata (ram_rdata),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res       (step_res)
    );

    assign res_valid     = res_valid_reg;
    assign best_start    = res_reg.best_start;
    assign best_length   = res_reg.best_length;
    assign window_start  = res_reg.window_start;
    assign window_length = res_reg.window_length;
    assign overflow      = res_reg.overflow;

    // Input is held back only while the update stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        sym_stall |-> s1_valid_reg)
        else $error("input stalled with an empty update stage");

    // An accepted transaction lands in the update stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> s1_valid_reg)
        else $error("accepted transaction lost");

    // A transaction leaving the update stage becomes a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("result dropped from the output register");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the longest unique run tracker. A short table of
// directed symbols is followed by one string long enough to overflow and then
// by random strings over alphabets of varied size. Every accepted input
// transaction is run through a behavioral tracker and each result transaction
// is compared with the oldest prediction, under random idling on both sides.
// ============================================================================
module tb_top;

    localparam int SYMBOL_W      = lurt_pkg::SYMBOL_W;
    localparam int START_W       = lurt_pkg::START_W;
    localparam int LEN_W         = lurt_pkg::LEN_W;
    localparam int STRING_LIMIT  = lurt_pkg::MAX_LEN_DEF;
    localparam int TABLE_DEPTH   = 1 << lurt_pkg::SYMBOL_BITS_DEF;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int PRESSURE_AT   = 400;
    localparam int DRAIN_AT      = 900;
    localparam int QUIET_AT      = 1300;
    localparam int HOLD_CYCLES   = 300;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int REPORT_MAX    = 10;
    localparam int DIRECTED_ROWS = 21;

    typedef lurt_pkg::res_t res_t;

    // One directed row; the expected result is used only when typed is set.
    typedef struct packed {
        logic [SYMBOL_W-1:0] sym;
        logic                first;
        logic                typed;
        res_t                want;
    } dir_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                sym_valid = 1'b0;
    logic                sym_stall;
    logic [SYMBOL_W-1:0] symbol    = '0;
    logic                first     = 1'b0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [START_W-1:0]  best_start;
    logic [LEN_W-1:0]    best_length;
    logic [START_W-1:0]  window_start;
    logic [LEN_W-1:0]    window_length;
    logic                overflow;

    // Shared controls between the sender, the receiver and the checker.
    res_t expected_runs[$];
    int   fail_count = 0;
    int   idle_pct   = 0;
    bit   quiet      = 1'b0;
    bit   hold_req   = 1'b0;

    // Behavioral copy of the tracker state.
    bit seen_mark[TABLE_DEPTH];
    int last_seen_at[TABLE_DEPTH];
    int taken_count = 0;
    int window_from = 0;
    int best_from   = 0;
    int best_len    = 0;

    longest_unique_run_tracker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .sym_valid     (sym_valid),
        .sym_stall     (sym_stall),
        .symbol        (symbol),
        .first         (first),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .best_start    (best_start),
        .best_length   (best_length),
        .window_start  (window_start),
        .window_length (window_length),
        .overflow      (overflow)
    );

    // Clock generation.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Advances the tracker by one symbol and returns the result it reports.
    function automatic res_t track_symbol(input logic [SYMBOL_W-1:0] sym, input logic is_first);
        res_t r;
        int   idx;
        int   wlen;
        idx = int'(sym) & (TABLE_DEPTH - 1);
        if (is_first)
        begin
            foreach (seen_mark[k]) seen_mark[k] = 1'b0;
            taken_count = 0;
            window_from = 0;
            best_from   = 0;
            best_len    = 0;
        end
        r.overflow = 1'b0;
        if (taken_count >= STRING_LIMIT)
        begin
            // The string is full: the symbol is dropped and nothing moves.
            r.overflow = 1'b1;
        end
        else
        begin
            // A repeat inside the window pulls the start past the old copy.
            if (seen_mark[idx] && last_seen_at[idx] >= window_from)
                window_from = last_seen_at[idx] + 1;
            last_seen_at[idx] = taken_count;
            seen_mark[idx]    = 1'b1;
            taken_count++;
            wlen = taken_count - window_from;
            // Strictly longer only, so the earlier run wins a tie.
            if (wlen > best_len)
            begin
                best_len  = wlen;
                best_from = window_from;
            end
        end
        r.best_start    = START_W'(best_from);
        r.best_length   = LEN_W'(best_len);
        r.window_start  = START_W'(window_from);
        r.window_length = LEN_W'(taken_count - window_from);
        return r;
    endfunction

    // Offers one symbol, waits for its transaction and records the expectation.
    task automatic offer_symbol(input logic [SYMBOL_W-1:0] sym, input logic is_first,
                                input logic use_typed = 1'b0, input res_t typed = '0);
        res_t predicted;
        if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            sym_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        sym_valid <= 1'b1;
        symbol    <= sym;
        first     <= is_first;
        @(posedge clk);
        while (sym_stall) @(posedge clk);
        predicted = track_symbol(sym, is_first);
        expected_runs.push_back(use_typed ? typed : predicted);
    endtask

    // Holds the input side quiet until every predicted result has arrived.
    task automatic drain_results();
        sym_valid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge clk);
    endtask

    // Stimulus: directed table, one overflowing string, then random strings.
    initial
    begin : stimulus
        dir_row_t dir_rows [DIRECTED_ROWS];
        int       sent;
        int       str_len;
        int       alpha;
        int       base;
        logic     str_first;

        dir_rows = '{
            '{8'h00, 1'b0, 1'b1, '{12'd0, 13'd1, 12'd0, 13'd1, 1'b0}},
            '{8'hFF, 1'b0, 1'b1, '{12'd0, 13'd2, 12'd0, 13'd2, 1'b0}},
            '{8'hFF, 1'b0, 1'b1, '{12'd0, 13'd2, 12'd2, 13'd1, 1'b0}},
            '{8'h00, 1'b0, 1'b1, '{12'd0, 13'd2, 12'd2, 13'd2, 1'b0}},
            '{8'h55, 1'b0, 1'b0, '0},
            '{8'hAA, 1'b1, 1'b1, '{12'd0, 13'd1, 12'd0, 13'd1, 1'b0}},
            '{8'hAA, 1'b1, 1'b1, '{12'd0, 13'd1, 12'd0, 13'd1, 1'b0}},
            '{8'h10, 1'b0, 1'b0, '0},
            '{8'h20, 1'b0, 1'b0, '0},
            '{8'h10, 1'b0, 1'b0, '0},
            '{8'h30, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'h7F, 1'b0, 1'b0, '0},
            '{8'h30, 1'b0, 1'b0, '0},
            '{8'h10, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b1, '{12'd0, 13'd1, 12'd0, 13'd1, 1'b0}},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows start straight from reset, without a first flag.
        idle_pct = 10;
        foreach (dir_rows[r])
            offer_symbol(dir_rows[r].sym, dir_rows[r].first, dir_rows[r].typed,
                         dir_rows[r].want);
        drain_results();

        // One string past the length limit; a counting prefix grows the
        // window to the full alphabet before random symbols take over.
        for (int i = 0; i < STRING_LIMIT + 24; i++)
            offer_symbol((i < 600) ? SYMBOL_W'(i) : SYMBOL_W'($urandom_range(0, 255)),
                         i == 0);

        // Random strings over alphabets of varied size and offset.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            str_len = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 300)
                                                   : $urandom_range(1, 40);
            case ($urandom_range(0, 4))
                0: alpha = 2;
                1: alpha = 4;
                2: alpha = 16;
                3: alpha = 64;
                default: alpha = 256;
            endcase
            base      = $urandom_range(0, 255);
            str_first = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 5;
                default: idle_pct = 25;
            endcase
            for (int i = 0; i < str_len && sent < RANDOM_ITEMS; i++)
            begin
                if (sent == PRESSURE_AT)
                    hold_req = 1'b1;
                if (sent == DRAIN_AT)
                    drain_results();
                if (sent == QUIET_AT)
                    quiet = 1'b1;
                offer_symbol(SYMBOL_W'(base + $urandom_range(0, alpha - 1)),
                             (i == 0) ? str_first : 1'b0);
                sent++;
            end
        end

        // Wait out the pipeline, then report.
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver idling: segments of varied density, plus one long hold-off.
    initial
    begin : result_stall_gen
        int stall_pct;
        int seg_left;
        stall_pct = 0;
        seg_left  = 0;
        forever
        begin
            @(posedge clk);
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    2: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
            seg_left--;
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            got = '{best_start, best_length, window_start, window_length, overflow};
            if (expected_runs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: best %0d/%0d window %0d/%0d ovf %0b",
                             got.best_start, got.best_length, got.window_start,
                             got.window_length, got.overflow);
            end
            else
            begin
                want = expected_runs.pop_front();
                if (got.best_start !== want.best_start ||
                    got.best_length !== want.best_length ||
                    got.window_start !== want.window_start ||
                    got.window_length !== want.window_length ||
                    got.overflow !== want.overflow)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"mismatch: best %0d/%0d window %0d/%0d ovf %0b, ",
                                  "expected best %0d/%0d window %0d/%0d ovf %0b"},
                                 got.best_start, got.best_length, got.window_start,
                                 got.window_length, got.overflow,
                                 want.best_start, want.best_length, want.window_start,
                                 want.window_length, want.overflow);
                end
            end
        end
    end

    // Watchdog: too many cycles without any transaction ends the run.
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if ((sym_valid && !sym_stall) || (res_valid && !res_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
sv/lurt_pkg.sv
sv/lurt_pos_ram.sv
sv/lurt_step.sv
sv/longest_unique_run_tracker.sv
test/tb_top.sv
